>>> sv/pcm_pkg.sv
// pcm_pkg: shared constants, register codes and result type for the
// perspective coordinate mapper; no dependencies
`default_nettype none

package pcm_pkg;

    // payload field widths
    localparam int DEST_W = 14;
    localparam int OUT_W  = 16;
    localparam int OFS_W  = 16;
    localparam int SIZE_W = 16;
    localparam int DX_W   = OFS_W + 1;

    // parameter defaults
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_WIDTH_DEF  = 16;

    // register port
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    typedef enum logic [2:0] {
        REG_ROW0_XY  = 3'd0,
        REG_ROW1_XY  = 3'd1,
        REG_ROW2_XY  = 3'd2,
        REG_X_SHIFT  = 3'd3,
        REG_Y_SHIFT  = 3'd4,
        REG_W_CONST  = 3'd5,
        REG_SRC_SIZE = 3'd6,
        REG_DST_OFS  = 3'd7
    } t_reg_idx;

    localparam logic [63:0] RST_ROW0_XY = 64'h0000_0001_0000_0000;
    localparam logic [63:0] RST_ROW1_XY = 64'h0100_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_XY = 64'h0;
    localparam logic [63:0] RST_X_SHIFT = 64'h0;
    localparam logic [63:0] RST_Y_SHIFT = 64'h0;
    localparam logic [63:0] RST_W_CONST = 64'h0000_0001_0000_0000;
    localparam logic [31:0] RST_SRC_SIZE = 32'h0;
    localparam logic [31:0] RST_DST_OFS  = 32'h0;

    typedef struct packed {
        logic signed [OUT_W-1:0] src_col;
        logic signed [OUT_W-1:0] src_row;
        logic [OUT_W-1:0]        frac_col;
        logic [OUT_W-1:0]        frac_row;
        logic                    in_range;
        logic                    singular;
    } t_result;

endpackage

`default_nettype wire

>>> sv/pcm_pix_if.sv
// pcm_pix_if: destination pixel channel (valid, ready, coordinates)
// depends on pcm_pkg
`default_nettype none

interface pcm_pix_if
    import pcm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;

    modport source(output valid, dest_x, dest_y, input ready);
    modport sink(input valid, dest_x, dest_y, output ready);
endinterface

`default_nettype wire

>>> sv/pcm_map_if.sv
// pcm_map_if: mapped source coordinate channel (valid, ready, result fields)
// depends on pcm_pkg
`default_nettype none

interface pcm_map_if
    import pcm_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] src_col;
    logic signed [OUT_W-1:0] src_row;
    logic [OUT_W-1:0]        frac_col;
    logic [OUT_W-1:0]        frac_row;
    logic                    in_range;
    logic                    singular;

    modport source(output valid, src_col, src_row, frac_col, frac_row, in_range, singular,
                   input ready);
    modport sink(input valid, src_col, src_row, frac_col, frac_row, in_range, singular,
                 output ready);
endinterface

`default_nettype wire

>>> sv/perspective_coordinate_mapper.sv
// perspective_coordinate_mapper: pipelined inverse homography mapping
// depends on pcm_pkg, pcm_pix_if, pcm_map_if
//
// usage:
//  - i_pix carries one destination pixel (dest_x, dest_y) per item; o_map returns
//    one item per pixel: floored source column and row (saturated), 0.FRAC_WIDTH
//    fractions, an in-range flag for the 2x2 neighbourhood and a singular flag
//  - coefficients, source size and destination offset sit in eight registers (six
//    64-bit, two 32-bit) on the apb port at byte address 8*index; write them while idle
//  - throughput is one item per cycle while the receiver keeps o_map.ready high;
//    the restoring divider resolves one quotient bit per pipeline stage
//  - reset (synchronous, active low) restores the register defaults and empties
//    the pipeline
//  - when the receiver stalls, the item behind the output register drops into a
//    skid register; only then does i_pix.ready fall and the whole pipeline hold,
//    so nothing is lost or repeated
`default_nettype none

module perspective_coordinate_mapper
    import pcm_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_WIDTH  = FRAC_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    pcm_pix_if.sink                i_pix,
    pcm_map_if.source              o_map
);

    // integer quotient bits resolved by the divider
    localparam int KI    = (COORD_WIDTH > SIZE_W) ? COORD_WIDTH : SIZE_W;
    localparam int NSTEP = KI + FRAC_WIDTH;
    localparam int RW    = 64 + KI;
    localparam int IPW   = KI + 1;
    localparam int PW    = 32 + DX_W;
    localparam int SW    = PW + 1;
    localparam logic [IPW-1:0] LIM = IPW'(1) << (COORD_WIDTH - 1);

    typedef struct packed {
        logic                  neg;
        logic                  big;
        logic [IPW-1:0]        ip;
        logic [FRAC_WIDTH-1:0] fr;
    } t_axis;

    typedef struct packed {
        logic             ok;
        logic [OUT_W-1:0] coord;
        logic [OUT_W-1:0] frac;
    } t_fin;

    // ---------------------------------------------------------------- registers
    logic [63:0] r_row0, r_row1, r_row2, r_xsh, r_ysh, r_wc;
    logic [31:0] r_size, r_ofs;
    logic        wr_en;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= RST_ROW0_XY;
            r_row1 <= RST_ROW1_XY;
            r_row2 <= RST_ROW2_XY;
            r_xsh  <= RST_X_SHIFT;
            r_ysh  <= RST_Y_SHIFT;
            r_wc   <= RST_W_CONST;
            r_size <= RST_SRC_SIZE;
            r_ofs  <= RST_DST_OFS;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ROW0_XY:  r_row0 <= pwdata;
                REG_ROW1_XY:  r_row1 <= pwdata;
                REG_ROW2_XY:  r_row2 <= pwdata;
                REG_X_SHIFT:  r_xsh  <= pwdata;
                REG_Y_SHIFT:  r_ysh  <= pwdata;
                REG_W_CONST:  r_wc   <= pwdata;
                REG_SRC_SIZE: r_size <= pwdata[31:0];
                REG_DST_OFS:  r_ofs  <= pwdata[31:0];
                default:      r_ofs  <= r_ofs;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROW0_XY:  prdata = r_row0;
            REG_ROW1_XY:  prdata = r_row1;
            REG_ROW2_XY:  prdata = r_row2;
            REG_X_SHIFT:  prdata = r_xsh;
            REG_Y_SHIFT:  prdata = r_ysh;
            REG_W_CONST:  prdata = r_wc;
            REG_SRC_SIZE: prdata = 64'(r_size);
            REG_DST_OFS:  prdata = 64'(r_ofs);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- helpers
    // add with clamp to the signed 64-bit range
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // one restoring step against the divisor scaled by 2^KI
    function automatic logic [RW:0] div_step(input logic [RW-1:0] r, input logic [63:0] b);
        logic [RW-1:0] t, d;
        logic          ge;
        t  = {r[RW-2:0], 1'b0};
        d  = {b, {KI{1'b0}}};
        ge = (t >= d);
        return {ge, ge ? t - d : t};
    endfunction

    // turn the truncated magnitude quotient into a floored signed one
    function automatic t_axis post(input logic [NSTEP-1:0] q, input logic rnz,
                                   input logic n, input logic big);
        logic [FRAC_WIDTH:0] f1;
        logic                fnz;
        t_axis               o;
        f1    = (FRAC_WIDTH+1)'(q[FRAC_WIDTH-1:0]) + (FRAC_WIDTH+1)'(rnz);
        fnz   = (f1 != '0);
        o.big = big;
        if (!n) begin
            o.ip  = IPW'(q[NSTEP-1:FRAC_WIDTH]);
            o.fr  = q[FRAC_WIDTH-1:0];
            o.neg = 1'b0;
        end else begin
            o.ip  = IPW'(q[NSTEP-1:FRAC_WIDTH]) + IPW'(fnz);
            o.fr  = FRAC_WIDTH'(~f1 + 1'b1);
            o.neg = big | (o.ip != '0);
        end
        return o;
    endfunction

    // saturation, field packing and neighbourhood test
    function automatic t_fin finish(input t_axis a, input logic [SIZE_W-1:0] size);
        logic                         satp, satn;
        logic signed [COORD_WIDTH-1:0] c;
        logic [FRAC_WIDTH-1:0]        f;
        t_fin                         o;
        satp = !a.neg && (a.big || a.ip >= LIM);
        satn = a.neg && (a.big || a.ip > LIM);
        f    = a.fr;
        if (satp) begin
            c = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            f = '0;
        end else if (satn) begin
            c = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            f = '0;
        end else begin
            c = a.neg ? COORD_WIDTH'(~a.ip + 1'b1) : COORD_WIDTH'(a.ip);
        end
        o.coord = OUT_W'(32'(c));
        o.frac  = OUT_W'(32'(f));
        o.ok    = !a.neg && !a.big && ((IPW+1)'(a.ip) + 1'b1 < (IPW+1)'(size));
        return o;
    endfunction

    // ---------------------------------------------------------------- flow control
    logic    en;
    logic    r_va, r_vb, r_vc, r_vd, r_ve, r_vg;
    logic    r_vdiv [NSTEP+1];
    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid, n_res;

    // pipeline holds only while the skid register is occupied
    assign en          = !r_skid_v;
    assign i_pix.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vg <= 1'b0;
            for (int s = 0; s <= NSTEP; s++) begin
                r_vdiv[s] <= 1'b0;
            end
        end else if (en) begin
            r_va      <= i_pix.valid;
            r_vb      <= r_va;
            r_vc      <= r_vb;
            r_vd      <= r_vc;
            r_ve      <= r_vd;
            r_vdiv[0] <= r_ve;
            for (int s = 1; s <= NSTEP; s++) begin
                r_vdiv[s] <= r_vdiv[s-1];
            end
            r_vg <= r_vdiv[NSTEP];
        end
    end

    // ---------------------------------------------------------------- stage a: offsets
    logic signed [DX_W-1:0] r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= DX_W'(signed'({1'b0, i_pix.dest_x})) + DX_W'(signed'(r_ofs[15:0]));
            r_dy <= DX_W'(signed'({1'b0, i_pix.dest_y})) + DX_W'(signed'(r_ofs[31:16]));
        end
    end

    // ---------------------------------------------------------------- stage b: products
    logic signed [PW-1:0] r_p0, r_p1, r_p3, r_p4, r_p6, r_p7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0 <= PW'(signed'(r_row0[31:0]))  * PW'(r_dx);
            r_p1 <= PW'(signed'(r_row0[63:32])) * PW'(r_dy);
            r_p3 <= PW'(signed'(r_row1[31:0]))  * PW'(r_dx);
            r_p4 <= PW'(signed'(r_row1[63:32])) * PW'(r_dy);
            r_p6 <= PW'(signed'(r_row2[31:0]))  * PW'(r_dx);
            r_p7 <= PW'(signed'(r_row2[63:32])) * PW'(r_dy);
        end
    end

    // ---------------------------------------------------------------- stage c: dot products
    logic signed [SW-1:0] r_sx, r_sy, r_sw;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx <= SW'(r_p0) + SW'(r_p1);
            r_sy <= SW'(r_p3) + SW'(r_p4);
            r_sw <= SW'(r_p6) + SW'(r_p7);
        end
    end

    // ---------------------------------------------------------------- stage d: to q32.32, add terms
    logic signed [63:0] r_num_x, r_num_y, r_den;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // q8.24 products move up by 2^8; the w row drops 8 bits with floor
            r_num_x <= sat_add(signed'(r_xsh), 64'(signed'({r_sx, 8'd0})));
            r_num_y <= sat_add(signed'(r_ysh), 64'(signed'({r_sy, 8'd0})));
            r_den   <= sat_add(signed'(r_wc), 64'(r_sw >>> 8));
        end
    end

    // ---------------------------------------------------------------- stage e: signs, magnitudes
    logic [63:0] r_ax, r_ay, r_b;
    logic        r_enx, r_eny, r_esg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax  <= r_num_x[63] ? ~r_num_x + 1'b1 : r_num_x;
            r_ay  <= r_num_y[63] ? ~r_num_y + 1'b1 : r_num_y;
            r_b   <= r_den[63] ? ~r_den + 1'b1 : r_den;
            r_enx <= r_num_x[63] ^ r_den[63];
            r_eny <= r_num_y[63] ^ r_den[63];
            r_esg <= (r_den == '0);
        end
    end

    // ---------------------------------------------------------------- divider stages
    // entry stage checks for a quotient too large for KI bits, then each
    // following stage resolves one bit of x and of y
    logic [RW-1:0]    r_rx [NSTEP+1];
    logic [RW-1:0]    r_ry [NSTEP+1];
    logic [63:0]      r_db [NSTEP+1];
    logic [NSTEP-1:0] r_qx [NSTEP+1];
    logic [NSTEP-1:0] r_qy [NSTEP+1];
    logic             r_nx [NSTEP+1];
    logic             r_ny [NSTEP+1];
    logic             r_bx [NSTEP+1];
    logic             r_by [NSTEP+1];
    logic             r_sg [NSTEP+1];
    logic [RW-1:0]    n_rx [1:NSTEP];
    logic [RW-1:0]    n_ry [1:NSTEP];
    logic             n_gx [1:NSTEP];
    logic             n_gy [1:NSTEP];

    always_comb begin
        for (int s = 1; s <= NSTEP; s++) begin
            {n_gx[s], n_rx[s]} = div_step(r_rx[s-1], r_db[s-1]);
            {n_gy[s], n_ry[s]} = div_step(r_ry[s-1], r_db[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx[0] <= RW'(r_ax);
            r_ry[0] <= RW'(r_ay);
            r_db[0] <= r_b;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_nx[0] <= r_enx;
            r_ny[0] <= r_eny;
            r_bx[0] <= (RW'(r_ax) >= {r_b, {KI{1'b0}}});
            r_by[0] <= (RW'(r_ay) >= {r_b, {KI{1'b0}}});
            r_sg[0] <= r_esg;
            for (int s = 1; s <= NSTEP; s++) begin
                r_rx[s] <= n_rx[s];
                r_ry[s] <= n_ry[s];
                r_db[s] <= r_db[s-1];
                r_qx[s] <= {r_qx[s-1][NSTEP-2:0], n_gx[s]};
                r_qy[s] <= {r_qy[s-1][NSTEP-2:0], n_gy[s]};
                r_nx[s] <= r_nx[s-1];
                r_ny[s] <= r_ny[s-1];
                r_bx[s] <= r_bx[s-1];
                r_by[s] <= r_by[s-1];
                r_sg[s] <= r_sg[s-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage g: floor correction
    t_axis r_gx, r_gy;
    logic  r_gsg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gx  <= post(r_qx[NSTEP], r_rx[NSTEP] != '0, r_nx[NSTEP], r_bx[NSTEP]);
            r_gy  <= post(r_qy[NSTEP], r_ry[NSTEP] != '0, r_ny[NSTEP], r_by[NSTEP]);
            r_gsg <= r_sg[NSTEP];
        end
    end

    // ---------------------------------------------------------------- finish, output and skid
    t_fin fin_x, fin_y;

    always_comb begin
        fin_x = finish(r_gx, r_size[15:0]);
        fin_y = finish(r_gy, r_size[31:16]);
        if (r_gsg) begin
            // zero divisor: all fields cleared
            n_res          = '0;
            n_res.singular = 1'b1;
        end else begin
            n_res.src_col  = signed'(fin_x.coord);
            n_res.src_row  = signed'(fin_y.coord);
            n_res.frac_col = fin_x.frac;
            n_res.frac_row = fin_y.frac;
            n_res.in_range = fin_x.ok & fin_y.ok;
            n_res.singular = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_map.ready) begin
            r_out_v  <= r_skid_v | (en & r_vg);
            r_skid_v <= 1'b0;
        end else if (en && r_vg) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_map.ready) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (en && r_vg) begin
            r_skid <= n_res;
        end
    end

    assign o_map.valid    = r_out_v;
    assign o_map.src_col  = r_out.src_col;
    assign o_map.src_row  = r_out.src_row;
    assign o_map.frac_col = r_out.frac_col;
    assign o_map.frac_row = r_out.frac_row;
    assign o_map.in_range = r_out.in_range;
    assign o_map.singular = r_out.singular;

endmodule

`default_nettype wire

>>> sv/pcm_checker.sv
// pcm_checker: port-level assertions on the mapper output channel, bound to
// perspective_coordinate_mapper; depends on pcm_pkg
`default_nettype none

module pcm_checker
    import pcm_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             i_ready,
    input wire logic [OUT_W-1:0] i_col,
    input wire logic [OUT_W-1:0] i_row,
    input wire logic [OUT_W-1:0] i_fcol,
    input wire logic [OUT_W-1:0] i_frow,
    input wire logic             i_in_range,
    input wire logic             i_singular
);

    // a stalled item stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_col) && $stable(i_row)
            && $stable(i_fcol) && $stable(i_frow))
        else $error("output item changed while stalled");

    // a zero divisor clears every result field
    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_singular |-> !i_in_range && i_col == '0 && i_row == '0
            && i_fcol == '0 && i_frow == '0)
        else $error("singular item with nonzero fields");

    // an in-range neighbourhood starts at a nonnegative source pixel
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_in_range |-> !i_col[OUT_W-1] && !i_row[OUT_W-1] && !i_singular)
        else $error("in-range item with negative coordinate");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid right after reset");

endmodule

bind perspective_coordinate_mapper pcm_checker u_pcm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_map.valid),
    .i_ready    (o_map.ready),
    .i_col      (o_map.src_col),
    .i_row      (o_map.src_row),
    .i_fcol     (o_map.frac_col),
    .i_frow     (o_map.frac_row),
    .i_in_range (o_map.in_range),
    .i_singular (o_map.singular)
);

`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking bench for perspective_coordinate_mapper
// depends on pcm_pkg, pcm_pix_if, pcm_map_if and the mapper rtl
// registers are set over apb while idle, pixels stream in, a scoreboard checks each item
`default_nettype none

// scoreboard: fixed-point inverse homography predictor and queue of pending mappings
class pcm_map_scoreboard;
    logic [63:0] row0_xy, row1_xy, row2_xy, x_shift, y_shift, w_const;
    logic [31:0] src_size, dst_ofs;
    pcm_pkg::t_result pending_maps[$];
    int mismatches;

    function new();
        row0_xy    = pcm_pkg::RST_ROW0_XY;
        row1_xy    = pcm_pkg::RST_ROW1_XY;
        row2_xy    = pcm_pkg::RST_ROW2_XY;
        x_shift    = pcm_pkg::RST_X_SHIFT;
        y_shift    = pcm_pkg::RST_Y_SHIFT;
        w_const    = pcm_pkg::RST_W_CONST;
        src_size   = pcm_pkg::RST_SRC_SIZE;
        dst_ofs    = pcm_pkg::RST_DST_OFS;
        mismatches = 0;
    endfunction

    function void set_reg(pcm_pkg::t_reg_idx idx, logic [63:0] value);
        case (idx)
            pcm_pkg::REG_ROW0_XY:  row0_xy  = value;
            pcm_pkg::REG_ROW1_XY:  row1_xy  = value;
            pcm_pkg::REG_ROW2_XY:  row2_xy  = value;
            pcm_pkg::REG_X_SHIFT:  x_shift  = value;
            pcm_pkg::REG_Y_SHIFT:  y_shift  = value;
            pcm_pkg::REG_W_CONST:  w_const  = value;
            pcm_pkg::REG_SRC_SIZE: src_size = value[31:0];
            pcm_pkg::REG_DST_OFS:  dst_ofs  = value[31:0];
            default: ;
        endcase
    endfunction

    // saturating 64-bit signed add, done in 66 bits
    function logic signed [63:0] sat_add(logic signed [65:0] a, logic signed [65:0] b);
        logic signed [65:0] s;
        s = a + b;
        if (s > 66'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -66'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // floor of num/den at 16 fraction bits, then saturate and judge the neighborhood
    function void map_axis(logic signed [63:0] num, logic signed [63:0] den,
                           logic [15:0] size, output logic [15:0] coord,
                           output logic [15:0] frac, output logic ok);
        logic signed [127:0] q;
        logic signed [127:0] ip;
        q     = ($signed({{64{num[63]}}, num}) <<< 16);
        // floor division of a signed value by a signed divisor
        ip    = q / den;
        if ((q % den) != 0 && ((q < 0) != (den < 0))) ip = ip - 1;
        frac  = ip[15:0];
        ip    = ip >>> 16;
        ok    = (ip >= 0) && (ip + 1 < size);
        if (ip > 32767) begin
            coord = 16'h7FFF;
            frac  = '0;
        end else if (ip < -32768) begin
            coord = 16'h8000;
            frac  = '0;
        end else begin
            coord = ip[15:0];
        end
    endfunction

    function void note_pixel(logic [13:0] dest_x, logic [13:0] dest_y);
        logic signed [63:0] dx, dy, x_num, y_num, w_den;
        logic signed [63:0] xs, ys, wp;
        logic okx, oky;
        pcm_pkg::t_result r;
        dx    = $signed({50'd0, dest_x}) + $signed(dst_ofs[15:0]);
        dy    = $signed({50'd0, dest_y}) + $signed(dst_ofs[31:16]);
        xs    = ($signed(row0_xy[31:0]) * dx + $signed(row0_xy[63:32]) * dy) * 256;
        ys    = ($signed(row1_xy[31:0]) * dx + $signed(row1_xy[63:32]) * dy) * 256;
        wp    = ($signed(row2_xy[31:0]) * dx + $signed(row2_xy[63:32]) * dy) >>> 8;
        x_num = sat_add($signed(x_shift), xs);
        y_num = sat_add($signed(y_shift), ys);
        w_den = sat_add($signed(w_const), wp);
        r     = '0;
        if (w_den == 0) begin
            r.singular = 1'b1;
        end else begin
            map_axis(x_num, w_den, src_size[15:0], r.src_col, r.frac_col, okx);
            map_axis(y_num, w_den, src_size[31:16], r.src_row, r.frac_row, oky);
            r.in_range = okx && oky;
        end
        pending_maps.push_back(r);
    endfunction

    function void check_map(pcm_pkg::t_result got);
        pcm_pkg::t_result exp;
        if (pending_maps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %p", got);
            return;
        end
        exp = pending_maps.pop_front();
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
        end
    endfunction
endclass

module tb_top;
    import pcm_pkg::*;

    localparam int LATENCY     = 39;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    pcm_pix_if i_pix ();
    pcm_map_if o_map ();

    // idle percentages of sender and receiver, changed per phase
    int send_idle = 0;
    int recv_stall = 0;
    int idle_count = 0;
    logic run_done = 1'b0;

    pcm_map_scoreboard sb;

    always #5 i_clk = ~i_clk;

    perspective_coordinate_mapper dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_pix(i_pix.sink), .o_map(o_map.source)
    );

    initial begin
        i_pix.valid  = 1'b0;
        i_pix.dest_x = '0;
        i_pix.dest_y = '0;
        o_map.ready  = 1'b0;
    end

    // receiver: random stalls, checks each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_map.valid && o_map.ready)
                sb.check_map('{o_map.src_col, o_map.src_row, o_map.frac_col,
                               o_map.frac_row, o_map.in_range, o_map.singular});
            o_map.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog: cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if ((i_pix.valid && i_pix.ready) || (o_map.valid && o_map.ready) || !i_rst_n
            || psel)
            idle_count <= 0;
        else if (!run_done)
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // apb write: setup cycle, then access cycle
    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(8 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // send one pixel, holding valid until accepted
    task automatic send_pixel(logic [13:0] x, logic [13:0] y);
        while ($urandom_range(99) < send_idle) begin
            i_pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        i_pix.valid  <= 1'b1;
        i_pix.dest_x <= x;
        i_pix.dest_y <= y;
        @(posedge i_clk);
        while (!i_pix.ready) @(posedge i_clk);
        sb.note_pixel(x, y);
    endtask

    task automatic drain();
        i_pix.valid <= 1'b0;
        while (sb.pending_maps.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // affine setup of the x and y coefficient rows and shifts
    task automatic set_affine(logic [31:0] h0, logic [31:0] h1, logic [31:0] h3,
                              logic [31:0] h4, logic [63:0] h2, logic [63:0] h5);
        write_reg(REG_ROW0_XY, {h1, h0});
        write_reg(REG_ROW1_XY, {h4, h3});
        write_reg(REG_X_SHIFT, h2);
        write_reg(REG_Y_SHIFT, h5);
    endtask

    // random mapping: mostly mild perspective, sometimes raw random bits
    task automatic random_config();
        logic [31:0] p0, p1;
        if ($urandom_range(3) == 0) begin
            write_reg(REG_ROW0_XY, {$urandom, $urandom});
            write_reg(REG_ROW1_XY, {$urandom, $urandom});
            write_reg(REG_ROW2_XY, {$urandom, $urandom});
            write_reg(REG_X_SHIFT, {$urandom, $urandom});
            write_reg(REG_Y_SHIFT, {$urandom, $urandom});
            write_reg(REG_W_CONST, {$urandom, $urandom});
        end else begin
            p0 = $urandom_range(32'h0200_0000) - 32'h0100_0000;
            p1 = $urandom_range(32'h0200_0000) - 32'h0100_0000;
            set_affine(32'h0100_0000 + p0, p1 >>> 3, p0 >>> 3, 32'h0100_0000 + p1,
                       {{32{1'b0}}, 32'(0)} - {$urandom_range(64), 32'h0} / 2
                           + {32'(0), $urandom},
                       {32'(0), $urandom});
            write_reg(REG_ROW2_XY, {32'($urandom_range(2000)) - 32'd1000,
                                    32'($urandom_range(2000)) - 32'd1000});
            write_reg(REG_W_CONST, {32'd1, $urandom});
        end
        write_reg(REG_SRC_SIZE, 64'({16'($urandom_range(2000)),
                                     16'($urandom_range(2000))}));
        write_reg(REG_DST_OFS, 64'($urandom));
    endtask

    initial begin
        logic [13:0] x, y;
        int n;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset mapping at field extremes
        write_reg(REG_SRC_SIZE, 64'({16'd1000, 16'd1000}));
        send_pixel(14'd0, 14'd0);
        send_pixel(14'h3FFF, 14'h3FFF);
        send_pixel(14'd998, 14'd998);
        send_pixel(14'd999, 14'd5);
        send_pixel(14'h2AAA, 14'h1555);
        drain();
        // offsets at both extremes, negative coordinates and saturation
        write_reg(REG_DST_OFS, 64'({16'h8000, 16'h7FFF}));
        send_pixel(14'd0, 14'd0);
        send_pixel(14'h3FFF, 14'h3FFF);
        drain();
        // half-scale gives fractions, a shift gives negative floors
        set_affine(32'h0080_0000, 32'h0, 32'h0, 32'hFF80_0000, 64'hFFFF_FFFF_8000_0000,
                   64'h7FFF_FFFF_FFFF_FFFF);
        write_reg(REG_DST_OFS, 64'h0);
        send_pixel(14'd3, 14'd3);
        send_pixel(14'd0, 14'd1);
        send_pixel(14'h3FFF, 14'd7);
        drain();
        // zero divisor sets singular
        write_reg(REG_W_CONST, 64'h0);
        send_pixel(14'd5, 14'd5);
        drain();
        // divisor from the projective row only, both signs
        write_reg(REG_ROW2_XY, {32'h8000_0000, 32'h7FFF_FFFF});
        send_pixel(14'd1, 14'd0);
        send_pixel(14'd0, 14'd1);
        send_pixel(14'h3FFF, 14'h3FFF);
        drain();
        // width and height of zero and one never give in_range
        write_reg(REG_W_CONST, 64'sh8000_0000_0000_0000);
        write_reg(REG_SRC_SIZE, 64'({16'd1, 16'd0}));
        send_pixel(14'd0, 14'd0);
        drain();
        write_reg(REG_SRC_SIZE, 64'h0000_0000_FFFF_FFFF);
        write_reg(REG_ROW2_XY, 64'h0);
        write_reg(REG_W_CONST, 64'h0000_0000_0000_0001);
        send_pixel(14'd1, 14'd1);
        send_pixel(14'd0, 14'd0);
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 76; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 76; end
                default: begin send_idle = 13; recv_stall = 13; end
            endcase
            random_config();
            n = 0;
            while (n < 88) begin
                x = 14'($urandom);
                y = 14'($urandom);
                if ($urandom_range(3) != 0) begin
                    x = 14'($urandom_range(2047));
                    y = 14'($urandom_range(2047));
                end
                send_pixel(x, y);
                n++;
            end
            drain();
        end

        run_done <= 1'b1;
        if (sb.mismatches == 0 && sb.pending_maps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

`default_nettype wire
